// File: sv/circle_span_rasterizer_core_macros.svh
`ifndef CIRCLE_SPAN_RASTERIZER_CORE_MACROS_SVH
`define CIRCLE_SPAN_RASTERIZER_CORE_MACROS_SVH

// Assertion helpers, clocked on clk_i and quiet while rst_ni is low.
`ifndef SYNTH

`define CSRAST_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define CSRAST_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define CSRAST_ASSERT_NOW(name, ante, cons, msg)

`define CSRAST_ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

// File: sv/csrast_pkg.sv
package csrast_pkg;

  localparam int COORD_BITS = 16;
  localparam int OUT_BITS   = COORD_BITS + 1;
  localparam int RAD_BITS   = 6;
  localparam int STEP_BITS  = RAD_BITS + 1;
  localparam int SQ_BITS    = 2 * RAD_BITS;
  localparam int NSQ_BITS   = 2 * STEP_BITS;
  localparam int PC_BITS    = 3;
  localparam int NSTEPS     = 1 << PC_BITS;

  typedef logic [PC_BITS-1:0] pc_t;

  // datapath operations, one per control word
  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_SQ_R,
    OP_ADV,
    OP_SQ_NX,
    OP_SQ_Y,
    OP_LOWER,
    OP_EMIT
  } op_e;

  // jump conditions; a jump not taken falls through to pc + 1
  typedef enum logic [2:0] {
    JC_NEXT,
    JC_NO_INPUT,
    JC_LOWER,
    JC_OUT_FULL,
    JC_MORE
  } jc_e;

  typedef struct packed {
    op_e op;
    jc_e jc;
    pc_t target;
  } uword_t;

  typedef struct packed {
    logic lower;     // y still too tall for the next column
    logic more;      // run continues after the current result
    logic out_full;  // output register holds a stalled result
  } dp_stat_t;

  localparam pc_t PC_IDLE  = pc_t'(0);
  localparam pc_t PC_SQ_R  = pc_t'(1);
  localparam pc_t PC_ADV   = pc_t'(2);
  localparam pc_t PC_SQ_NX = pc_t'(3);
  localparam pc_t PC_SQ_Y  = pc_t'(4);
  localparam pc_t PC_LOWER = pc_t'(5);
  localparam pc_t PC_WAIT  = pc_t'(6);
  localparam pc_t PC_EMIT  = pc_t'(7);

  // Program. EMIT falls through by wraparound back to idle.
  localparam uword_t UCODE [NSTEPS] = '{
    '{op: OP_LOAD,  jc: JC_NO_INPUT, target: PC_IDLE},
    '{op: OP_SQ_R,  jc: JC_NEXT,     target: PC_IDLE},
    '{op: OP_ADV,   jc: JC_NEXT,     target: PC_IDLE},
    '{op: OP_SQ_NX, jc: JC_NEXT,     target: PC_IDLE},
    '{op: OP_SQ_Y,  jc: JC_NEXT,     target: PC_IDLE},
    '{op: OP_LOWER, jc: JC_LOWER,    target: PC_SQ_Y},
    '{op: OP_NOP,   jc: JC_OUT_FULL, target: PC_WAIT},
    '{op: OP_EMIT,  jc: JC_MORE,     target: PC_ADV}
  };

endpackage

// File: sv/circle_span_rasterizer_core.sv
// Channel | Direction | Handshake             | Payload
// cfg     | in        | cfg_valid_i/cfg_ready_o | cfg_data_i (dedupe center column)
// in      | in        | in_valid_i/in_stall_o | kind, center_x, center_y, radius
// out     | out       | out_valid_o/out_stall_i | eight coordinates, span flag, kind, last
//
// One circle at a time, and output stalls can hold the run. Over a run y drops by r in total
// for a fill and by less for an outline; each unit drop costs a square and a compare in
// the microcode loop.
// Reset clears the step counter, output valid and sets dedupe to 1.
// out_stall_i holds the sequencer in its wait step; in_stall_o is low only when idle.
`include "circle_span_rasterizer_core_macros.svh"

module circle_span_rasterizer_core (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic                                    cfg_data_i,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic                                    kind_i,
  input  logic signed [csrast_pkg::COORD_BITS-1:0] center_x_i,
  input  logic signed [csrast_pkg::COORD_BITS-1:0] center_y_i,
  input  logic [csrast_pkg::RAD_BITS-1:0]         radius_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic signed [csrast_pkg::OUT_BITS-1:0]  col_plus_x_o,
  output logic signed [csrast_pkg::OUT_BITS-1:0]  col_minus_x_o,
  output logic signed [csrast_pkg::OUT_BITS-1:0]  row_plus_y_o,
  output logic signed [csrast_pkg::OUT_BITS-1:0]  row_minus_y_o,
  output logic signed [csrast_pkg::OUT_BITS-1:0]  col_plus_y_o,
  output logic signed [csrast_pkg::OUT_BITS-1:0]  col_minus_y_o,
  output logic signed [csrast_pkg::OUT_BITS-1:0]  row_plus_x_o,
  output logic signed [csrast_pkg::OUT_BITS-1:0]  row_minus_x_o,
  output logic                                    second_span_valid_o,
  output logic                                    result_kind_o,
  output logic                                    last_o
);
  import csrast_pkg::*;

  logic     dedupe_q;
  op_e      op;
  dp_stat_t stat;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (op != OP_LOAD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dedupe_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      dedupe_q <= cfg_data_i;
    end
  end

  csrast_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .op_o       (op)
  );

  csrast_datapath u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .op_i                (op),
    .dedupe_i            (dedupe_q),
    .in_valid_i          (in_valid_i),
    .kind_i              (kind_i),
    .center_x_i          (center_x_i),
    .center_y_i          (center_y_i),
    .radius_i            (radius_i),
    .out_stall_i         (out_stall_i),
    .stat_o              (stat),
    .out_valid_o         (out_valid_o),
    .col_plus_x_o        (col_plus_x_o),
    .col_minus_x_o       (col_minus_x_o),
    .row_plus_y_o        (row_plus_y_o),
    .row_minus_y_o       (row_minus_y_o),
    .col_plus_y_o        (col_plus_y_o),
    .col_minus_y_o       (col_minus_y_o),
    .row_plus_x_o        (row_plus_x_o),
    .row_minus_x_o       (row_minus_x_o),
    .second_span_valid_o (second_span_valid_o),
    .result_kind_o       (result_kind_o),
    .last_o              (last_o)
  );

  `CSRAST_ASSERT_NEXT(a_load_then_square, in_valid_i && !in_stall_o, op == OP_SQ_R,
                      "accepted request did not start the program")
  `CSRAST_ASSERT_NOW(a_rise_from_emit, $rose(out_valid_o), $past(op == OP_EMIT),
                     "result appeared without an emit step")
  `CSRAST_ASSERT_NOW(a_outline_no_span, out_valid_o && !result_kind_o, !second_span_valid_o,
                     "outline result carries a span flag")
  `CSRAST_ASSERT_NOW(a_dropped_span_center,
                     out_valid_o && result_kind_o && !second_span_valid_o,
                     col_plus_x_o == col_minus_x_o,
                     "second span dropped off the center column")

endmodule

// File: sv/csrast_sequencer.sv
module csrast_sequencer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  csrast_pkg::dp_stat_t stat_i,
  output csrast_pkg::op_e      op_o
);
  import csrast_pkg::*;

  pc_t    pc_q, pc_d;
  uword_t uw;
  logic   take;

  assign uw   = UCODE[pc_q];
  assign op_o = uw.op;

  always_comb begin
    unique case (uw.jc)
      JC_NEXT:     take = 1'b0;
      JC_NO_INPUT: take = !in_valid_i;
      JC_LOWER:    take = stat_i.lower;
      JC_OUT_FULL: take = stat_i.out_full;
      JC_MORE:     take = stat_i.more;
      default:     take = 1'b0;
    endcase
    pc_d = take ? uw.target : pc_q + pc_t'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PC_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

// File: sv/csrast_datapath.sv
module csrast_datapath (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  csrast_pkg::op_e                         op_i,
  input  logic                                    dedupe_i,
  input  logic                                    in_valid_i,
  input  logic                                    kind_i,
  input  logic signed [csrast_pkg::COORD_BITS-1:0] center_x_i,
  input  logic signed [csrast_pkg::COORD_BITS-1:0] center_y_i,
  input  logic [csrast_pkg::RAD_BITS-1:0]         radius_i,
  input  logic                                    out_stall_i,
  output csrast_pkg::dp_stat_t                    stat_o,
  output logic                                    out_valid_o,
  output logic signed [csrast_pkg::OUT_BITS-1:0]  col_plus_x_o,
  output logic signed [csrast_pkg::OUT_BITS-1:0]  col_minus_x_o,
  output logic signed [csrast_pkg::OUT_BITS-1:0]  row_plus_y_o,
  output logic signed [csrast_pkg::OUT_BITS-1:0]  row_minus_y_o,
  output logic signed [csrast_pkg::OUT_BITS-1:0]  col_plus_y_o,
  output logic signed [csrast_pkg::OUT_BITS-1:0]  col_minus_y_o,
  output logic signed [csrast_pkg::OUT_BITS-1:0]  row_plus_x_o,
  output logic signed [csrast_pkg::OUT_BITS-1:0]  row_minus_x_o,
  output logic                                    second_span_valid_o,
  output logic                                    result_kind_o,
  output logic                                    last_o
);
  import csrast_pkg::*;

  // request
  logic                        kind_q;
  logic signed [OUT_BITS-1:0]  cx_q, cy_q;
  logic [RAD_BITS-1:0]         r_q;
  // current and next column / height
  logic [STEP_BITS-1:0]        x_q, nx_q;
  logic [RAD_BITS-1:0]         y_q, ny_q;
  logic [SQ_BITS-1:0]          rr_q, t_q, yy_q;

  logic                        out_valid_q;
  logic signed [OUT_BITS-1:0]  cpx_q, cmx_q, rpy_q, rmy_q, cpy_q, cmy_q, rpx_q, rmx_q;
  logic                        ssv_q, rkind_q, last_q;

  logic [NSQ_BITS-1:0]         nsq;
  logic [NSQ_BITS-1:0]         rr_ext;
  logic signed [OUT_BITS-1:0]  xs, ys;
  logic                        last_now;

  assign nsq      = nx_q * nx_q;
  assign rr_ext   = NSQ_BITS'(rr_q);
  assign xs       = OUT_BITS'(signed'({1'b0, x_q}));
  assign ys       = OUT_BITS'(signed'({1'b0, y_q}));
  assign last_now = kind_q ? (nx_q > STEP_BITS'(r_q)) : (nx_q > STEP_BITS'(ny_q));

  assign stat_o.lower    = (ny_q != '0) && (yy_q > t_q);
  assign stat_o.more     = !last_now;
  assign stat_o.out_full = out_valid_q && out_stall_i;

  always_ff @(posedge clk_i) begin
    unique case (op_i)
      OP_LOAD: begin
        if (in_valid_i) begin
          kind_q <= kind_i;
          cx_q   <= OUT_BITS'(center_x_i);
          cy_q   <= OUT_BITS'(center_y_i);
          r_q    <= radius_i;
          x_q    <= '0;
          y_q    <= radius_i;
        end
      end
      OP_SQ_R:  rr_q <= SQ_BITS'(r_q * r_q);
      OP_ADV: begin
        nx_q <= x_q + STEP_BITS'(1);
        ny_q <= y_q;
      end
      // remaining height budget, clamped at zero past the radius
      OP_SQ_NX: t_q <= (nsq > rr_ext) ? '0 : SQ_BITS'(rr_ext - nsq);
      OP_SQ_Y:  yy_q <= SQ_BITS'(ny_q * ny_q);
      OP_LOWER: begin
        if (stat_o.lower) ny_q <= ny_q - RAD_BITS'(1);
      end
      OP_EMIT: begin
        x_q     <= nx_q;
        y_q     <= ny_q;
        cpx_q   <= cx_q + xs;
        cmx_q   <= cx_q - xs;
        rpy_q   <= cy_q + ys;
        rmy_q   <= cy_q - ys;
        rkind_q <= kind_q;
        last_q  <= last_now;
        if (kind_q) begin
          cpy_q <= '0;
          cmy_q <= '0;
          rpx_q <= '0;
          rmx_q <= '0;
          ssv_q <= !(x_q == '0 && dedupe_i);
        end else begin
          cpy_q <= cx_q + ys;
          cmy_q <= cx_q - ys;
          rpx_q <= cy_q + xs;
          rmx_q <= cy_q - xs;
          ssv_q <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  // sequencer only reaches EMIT with the output register free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (op_i == OP_EMIT) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign col_plus_x_o        = cpx_q;
  assign col_minus_x_o       = cmx_q;
  assign row_plus_y_o        = rpy_q;
  assign row_minus_y_o       = rmy_q;
  assign col_plus_y_o        = cpy_q;
  assign col_minus_y_o       = cmy_q;
  assign row_plus_x_o        = rpx_q;
  assign row_minus_x_o       = rmx_q;
  assign second_span_valid_o = ssv_q;
  assign result_kind_o       = rkind_q;
  assign last_o              = last_q;

endmodule

// File: dv/circle_span_tb_pkg.sv
package circle_span_tb_pkg;

  typedef enum logic {
    KIND_OUTLINE = 1'b0,
    KIND_FILL    = 1'b1
  } circle_kind_e;

endpackage

// File: dv/circle_span_checker.sv
module circle_span_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  input  logic                               cfg_ready_i,
  input  logic                               cfg_data_i,
  input  logic                               in_valid_i,
  input  logic                               in_stall_i,
  input  logic                               kind_i,
  input  logic [csrast_pkg::COORD_BITS-1:0]  center_x_i,
  input  logic [csrast_pkg::COORD_BITS-1:0]  center_y_i,
  input  logic [csrast_pkg::RAD_BITS-1:0]    radius_i,
  input  logic                               out_valid_i,
  input  logic                               out_stall_i,
  input  logic [csrast_pkg::OUT_BITS-1:0]    col_plus_x_i,
  input  logic [csrast_pkg::OUT_BITS-1:0]    col_minus_x_i,
  input  logic [csrast_pkg::OUT_BITS-1:0]    row_plus_y_i,
  input  logic [csrast_pkg::OUT_BITS-1:0]    row_minus_y_i,
  input  logic [csrast_pkg::OUT_BITS-1:0]    col_plus_y_i,
  input  logic [csrast_pkg::OUT_BITS-1:0]    col_minus_y_i,
  input  logic [csrast_pkg::OUT_BITS-1:0]    row_plus_x_i,
  input  logic [csrast_pkg::OUT_BITS-1:0]    row_minus_x_i,
  input  logic                               second_span_valid_i,
  input  logic                               result_kind_i,
  input  logic                               last_i,
  output int                                 mismatches_o,
  output int                                 pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  import csrast_pkg::*;
  import circle_span_tb_pkg::*;

  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [OUT_BITS-1:0] col_plus_x;
    logic [OUT_BITS-1:0] col_minus_x;
    logic [OUT_BITS-1:0] row_plus_y;
    logic [OUT_BITS-1:0] row_minus_y;
    logic [OUT_BITS-1:0] col_plus_y;
    logic [OUT_BITS-1:0] col_minus_y;
    logic [OUT_BITS-1:0] row_plus_x;
    logic [OUT_BITS-1:0] row_minus_x;
    logic                second_span_valid;
    logic                result_kind;
    logic                last;
  } circle_step_t;

  circle_step_t points_due_q[$];
  logic         dedupe_en;
  int           mismatch_count = 0;

  assign mismatches_o = mismatch_count;
  assign pending_o    = points_due_q.size();

  // Walks x up from 0 with y = floor(sqrt(r*r - x*x)), one expected result per step.
  task automatic rasterize_circle(input circle_kind_e k, input logic signed [COORD_BITS-1:0] cx_in,
                                  input logic signed [COORD_BITS-1:0] cy_in,
                                  input logic [RAD_BITS-1:0] rad);
    int           cx, cy, r, x, y, nx, ny, room;
    logic         more;
    circle_step_t step;
    cx = cx_in;
    cy = cy_in;
    r  = rad;
    x  = 0;
    y  = r;
    do begin
      nx   = x + 1;
      room = r * r - nx * nx;
      if (room < 0) room = 0;
      ny = y;
      while (ny > 0 && ny * ny > room) ny--;
      more = (k == KIND_FILL) ? (nx <= r) : (nx <= ny);

      step             = '0;
      step.col_plus_x  = OUT_BITS'(cx + x);
      step.col_minus_x = OUT_BITS'(cx - x);
      step.row_plus_y  = OUT_BITS'(cy + y);
      step.row_minus_y = OUT_BITS'(cy - y);
      if (k == KIND_OUTLINE) begin
        step.col_plus_y  = OUT_BITS'(cx + y);
        step.col_minus_y = OUT_BITS'(cx - y);
        step.row_plus_x  = OUT_BITS'(cy + x);
        step.row_minus_x = OUT_BITS'(cy - x);
      end else begin
        // centre column span shows up twice unless dedupe is on
        step.second_span_valid = !(x == 0 && dedupe_en);
      end
      step.result_kind = k;
      step.last        = !more;
      points_due_q.push_back(step);
      x = nx;
      y = ny;
    end while (more);
  endtask

  function automatic string format_step(input circle_step_t s);
    return $sformatf({"cpx=%0d cmx=%0d rpy=%0d rmy=%0d cpy=%0d cmy=%0d rpx=%0d rmx=%0d",
                      " span2=%0b kind=%0b last=%0b"},
                     $signed(s.col_plus_x), $signed(s.col_minus_x), $signed(s.row_plus_y),
                     $signed(s.row_minus_y), $signed(s.col_plus_y), $signed(s.col_minus_y),
                     $signed(s.row_plus_x), $signed(s.row_minus_x), s.second_span_valid,
                     s.result_kind, s.last);
  endfunction

  always @(posedge clk_i) begin
    circle_step_t seen, due;
    if (!rst_ni) begin
      dedupe_en = 1'b1;
    end else begin
      if (cfg_valid_i && cfg_ready_i) dedupe_en = cfg_data_i;

      if (out_valid_i && !out_stall_i) begin
        seen = '{col_plus_x_i, col_minus_x_i, row_plus_y_i, row_minus_y_i, col_plus_y_i,
                 col_minus_y_i, row_plus_x_i, row_minus_x_i, second_span_valid_i,
                 result_kind_i, last_i};
        if (points_due_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: result with none pending: %s", $time, format_step(seen));
        end else begin
          due = points_due_q.pop_front();
          if (seen !== due) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
              $display("%0t: result mismatch", $time);
              $display("  expected %s", format_step(due));
              $display("  actual   %s", format_step(seen));
            end
          end
        end
      end

      if (in_valid_i && !in_stall_i)
        rasterize_circle(circle_kind_e'(kind_i), center_x_i, center_y_i, radius_i);
    end
  end

endmodule

// File: dv/tb_top.sv
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  import csrast_pkg::*;
  import circle_span_tb_pkg::*;

  localparam int CLK_PERIOD  = 20;
  localparam int RESET_TICKS = 9;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 5000;
  localparam int TAIL_CYCLES = 40;
  localparam int PHASE_ITEMS = 60;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_data = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  kind = 1'b0;
  logic [COORD_BITS-1:0] center_x = '0;
  logic [COORD_BITS-1:0] center_y = '0;
  logic [RAD_BITS-1:0]   radius = '0;
  logic                  out_stall = 1'b0;

  logic                  cfg_ready, in_stall, out_valid;
  logic [OUT_BITS-1:0]   col_plus_x, col_minus_x, row_plus_y, row_minus_y;
  logic [OUT_BITS-1:0]   col_plus_y, col_minus_y, row_plus_x, row_minus_x;
  logic                  second_span_valid, result_kind, last;

  int                    mismatches, pending;
  logic                  idling_on = 1'b1;
  logic                  hold_req = 1'b0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  circle_span_rasterizer_core uut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_o         (cfg_ready),
    .cfg_data_i          (cfg_data),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .kind_i              (kind),
    .center_x_i          (center_x),
    .center_y_i          (center_y),
    .radius_i            (radius),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .col_plus_x_o        (col_plus_x),
    .col_minus_x_o       (col_minus_x),
    .row_plus_y_o        (row_plus_y),
    .row_minus_y_o       (row_minus_y),
    .col_plus_y_o        (col_plus_y),
    .col_minus_y_o       (col_minus_y),
    .row_plus_x_o        (row_plus_x),
    .row_minus_x_o       (row_minus_x),
    .second_span_valid_o (second_span_valid),
    .result_kind_o       (result_kind),
    .last_o              (last)
  );

  circle_span_checker checker_i (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_i         (cfg_ready),
    .cfg_data_i          (cfg_data),
    .in_valid_i          (in_valid),
    .in_stall_i          (in_stall),
    .kind_i              (kind),
    .center_x_i          (center_x),
    .center_y_i          (center_y),
    .radius_i            (radius),
    .out_valid_i         (out_valid),
    .out_stall_i         (out_stall),
    .col_plus_x_i        (col_plus_x),
    .col_minus_x_i       (col_minus_x),
    .row_plus_y_i        (row_plus_y),
    .row_minus_y_i       (row_minus_y),
    .col_plus_y_i        (col_plus_y),
    .col_minus_y_i       (col_minus_y),
    .row_plus_x_i        (row_plus_x),
    .row_minus_x_i       (row_minus_x),
    .second_span_valid_i (second_span_valid),
    .result_kind_i       (result_kind),
    .last_i              (last),
    .mismatches_o        (mismatches),
    .pending_o           (pending)
  );

  // Leaves valid high after a transfer; the next call either replaces the item or drops valid.
  task automatic send_circle(input circle_kind_e k, input logic [COORD_BITS-1:0] cx,
                             input logic [COORD_BITS-1:0] cy, input logic [RAD_BITS-1:0] r);
    if (idling_on && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    kind     <= k;
    center_x <= cx;
    center_y <= cy;
    radius   <= r;
    do @(posedge clk_i); while (in_stall);
  endtask

  // Drop valid and wait for every predicted result to come out.
  task automatic drain;
    in_valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
  endtask

  task automatic write_dedupe(input logic value);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [COORD_BITS-1:0] pick_center();
    if ($urandom_range(0, 7) == 0) begin
      if ($urandom_range(0, 1) == 1)
        return COORD_BITS'(16'h7FFF - $urandom_range(0, 63));
      return COORD_BITS'(16'h8000 + $urandom_range(0, 63));
    end
    return COORD_BITS'($urandom);
  endfunction

  // Output side: random stall bursts, free-running stretches, and one long hold-off.
  initial begin : receiver
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (idling_on && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((cfg_valid && cfg_ready) || (in_valid && !in_stall) || (out_valid && !out_stall))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    logic [RAD_BITS-1:0] r;
    circle_kind_e        k;
    repeat (RESET_TICKS) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_dedupe(1'b1);
    send_circle(KIND_OUTLINE, 16'h0000, 16'h0000, 6'd0);
    send_circle(KIND_FILL,    16'h0000, 16'h0000, 6'd0);
    send_circle(KIND_OUTLINE, 16'h0001, 16'hFFFF, 6'd1);
    send_circle(KIND_FILL,    16'h0001, 16'hFFFF, 6'd1);
    send_circle(KIND_OUTLINE, 16'h7FFF, 16'h7FFF, 6'd63);
    send_circle(KIND_FILL,    16'h8000, 16'h8000, 6'd63);
    send_circle(KIND_OUTLINE, 16'h8000, 16'h8000, 6'd63);
    send_circle(KIND_FILL,    16'h7FFF, 16'h7FFF, 6'd63);
    send_circle(KIND_OUTLINE, 16'h5555, 16'hAAAA, 6'd7);
    send_circle(KIND_FILL,    16'hAAAA, 16'h5555, 6'd42);
    send_circle(KIND_OUTLINE, 16'h0000, 16'hFFFF, 6'd21);
    send_circle(KIND_FILL,    16'hFFFF, 16'h0000, 6'd2);
    drain();

    // centre column drawn twice with dedupe off
    write_dedupe(1'b0);
    send_circle(KIND_FILL,    16'h0000, 16'h0000, 6'd0);
    send_circle(KIND_FILL,    16'h0000, 16'h0000, 6'd1);
    send_circle(KIND_FILL,    16'h0064, 16'hFF9C, 6'd5);
    send_circle(KIND_OUTLINE, 16'h0064, 16'hFF9C, 6'd5);
    send_circle(KIND_FILL,    16'h0000, 16'h0000, 6'd63);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      write_dedupe((phase == 2) ? 1'($urandom) : 1'(phase % 2 == 0));
      idling_on = (phase < 3);
      if (phase == 1) hold_req = 1'b1;
      repeat (PHASE_ITEMS) begin
        k = circle_kind_e'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
          0:       r = '0;
          1:       r = RAD_BITS'($urandom_range(32, 63));
          default: r = RAD_BITS'($urandom_range(1, 12));
        endcase
        send_circle(k, pick_center(), pick_center(), r);
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (mismatches == 0 && pending == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/csrast_pkg.sv
sv/csrast_sequencer.sv
sv/csrast_datapath.sv
sv/circle_span_rasterizer_core.sv
dv/circle_span_tb_pkg.sv
dv/circle_span_checker.sv
dv/tb_top.sv
